FILE: rtl/klic_pkg.sv
// ----------------------------------------------------------------------------
// klic_pkg - shared types and constants for the knob level controller
// Event kinds, phases, register indices, reset values, the state and result
// records, and the small progress-to-level tables.
// ----------------------------------------------------------------------------
`default_nettype none

package klic_pkg;

  // Level geometry
  localparam int STEPS_PER_LEVEL = 3;
  localparam int NUM_LEVELS      = 5;
  localparam int MAX_PROGRESS    = NUM_LEVELS * STEPS_PER_LEVEL - 1;
  localparam int PROG_W          = $clog2(MAX_PROGRESS + 1);
  localparam int LEVEL_W         = 3;
  localparam int SUB_W           = 2;
  localparam int LIDX_W          = $clog2(NUM_LEVELS);

  // Field widths
  localparam int KIND_W  = 3;
  localparam int TIME_W  = 32;
  localparam int DELTA_W = 8;
  localparam int REQ_W   = 8;
  localparam int CIDX_W  = 3;
  localparam int SUM_W   = DELTA_W + PROG_W;

  // Register reset values
  localparam logic [TIME_W-1:0] BOOT_HOLD_RST  = 32'd1000;
  localparam logic [TIME_W-1:0] INACT_TO_RST   = 32'd300000;
  localparam logic [TIME_W-1:0] DEBOUNCE_RST   = 32'd500;
  localparam logic [TIME_W-1:0] LONG_PRESS_RST = 32'd1500;
  localparam logic              INIT_TYPE_RST  = 1'b0;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK      = 3'd0,
    KIND_ENCODER   = 3'd1,
    KIND_BUTTON    = 3'd2,
    KIND_SET_LEVEL = 3'd3,
    KIND_RST_QUEUE = 3'd4,
    KIND_DISMISS   = 3'd5
  } kind_t;

  typedef enum logic {
    PHASE_BOOT = 1'b0,
    PHASE_HOME = 1'b1
  } phase_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_BOOT_HOLD  = 3'd0,
    CFG_INACT_TO   = 3'd1,
    CFG_DEBOUNCE   = 3'd2,
    CFG_LONG_PRESS = 3'd3,
    CFG_INIT_TYPE  = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [TIME_W-1:0] boot_hold;
    logic [TIME_W-1:0] idle_timeout;
    logic [TIME_W-1:0] dismiss_debounce_ms;
    logic [TIME_W-1:0] press_long;
    logic              init_unit_type;
  } cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [TIME_W-1:0]  now_ms;
    logic [DELTA_W-1:0] delta;
    logic               pressed;
    logic [TIME_W-1:0]  press_duration_ms;
    logic [REQ_W-1:0]   level_request;
  } ev_t;

  typedef struct packed {
    phase_t            phase;
    logic [TIME_W-1:0] phase_enter_time;
    logic [TIME_W-1:0] last_input_time;
    logic [TIME_W-1:0] dismiss_time;
    logic              dismiss_valid;
    logic [PROG_W-1:0] progress;
    logic              alert;
    logic              dev_type;
  } state_t;

  typedef struct packed {
    logic               phase;
    logic [LEVEL_W-1:0] level;
    logic [SUB_W-1:0]   detent;
    logic               inactive;
    logic               unit_type;
    logic               level_changed;
    logic               alert_dismissed;
  } res_t;

  // Level (1-based) for a progress value; constant table lookup
  function automatic logic [LEVEL_W-1:0] level_of(input logic [PROG_W-1:0] p);
    logic [LEVEL_W-1:0] lvl;
    lvl = LEVEL_W'(1);
    for (int i = 0; i < (1 << PROG_W); i++) begin
      if (p == PROG_W'(i)) begin
        if (i / STEPS_PER_LEVEL >= NUM_LEVELS) lvl = LEVEL_W'(NUM_LEVELS);
        else lvl = LEVEL_W'(i / STEPS_PER_LEVEL + 1);
      end
    end
    return lvl;
  endfunction

  // Detent position within the level; constant table lookup
  function automatic logic [SUB_W-1:0] sub_of(input logic [PROG_W-1:0] p);
    logic [SUB_W-1:0] sub;
    sub = '0;
    for (int i = 0; i < (1 << PROG_W); i++) begin
      if (p == PROG_W'(i)) sub = SUB_W'(i % STEPS_PER_LEVEL);
    end
    return sub;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/klic_step.sv
// ----------------------------------------------------------------------------
// klic_step - single-pass event update
// Applies one event to the controller state and forms the result item.
// Purely combinational; registered on both sides by the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module klic_step
  import klic_pkg::*;
(
  input  cfg_t   cfg,
  input  state_t cur,
  input  ev_t    ev,
  output state_t state_nxt,
  output res_t   res_nxt
);

  kind_t                    kind;
  logic [TIME_W-1:0]        d_enter;
  logic [TIME_W-1:0]        d_input;
  logic [TIME_W-1:0]        d_dismiss;
  logic signed [SUM_W-1:0]  prog_sum;
  logic [LIDX_W-1:0]        req_idx;
  logic                     changed;
  logic                     dismissed;

  assign kind      = kind_t'(ev.kind);
  assign d_enter   = ev.now_ms - cur.phase_enter_time;
  assign d_input   = ev.now_ms - cur.last_input_time;
  assign d_dismiss = ev.now_ms - cur.dismiss_time;

  // Progress plus signed detents, wide enough not to wrap
  assign prog_sum = $signed({{DELTA_W{1'b0}}, cur.progress})
                  + $signed({{PROG_W{ev.delta[DELTA_W-1]}}, ev.delta});

  // Requested level clamped to 1..NUM_LEVELS, as a 0-based index
  always_comb begin
    priority if (ev.level_request == '0)
      req_idx = '0;
    else if (ev.level_request > REQ_W'(NUM_LEVELS))
      req_idx = LIDX_W'(NUM_LEVELS - 1);
    else
      req_idx = LIDX_W'(ev.level_request - REQ_W'(1));
  end

  // Next state
  always_comb begin
    state_nxt = cur;
    changed   = 1'b0;
    dismissed = 1'b0;
    unique case (kind)
      KIND_TICK: begin
        if (cur.phase == PHASE_BOOT) begin
          if (d_enter > cfg.boot_hold) begin
            state_nxt.phase            = PHASE_HOME;
            state_nxt.phase_enter_time = ev.now_ms;
            state_nxt.last_input_time  = ev.now_ms;
          end
        end else if (!cur.alert && d_input >= cfg.idle_timeout) begin
          state_nxt.alert = 1'b1;
        end
      end
      KIND_ENCODER: begin
        if (ev.delta != '0) begin
          state_nxt.last_input_time = ev.now_ms;
          priority if (cur.alert) begin
            // first rotation only dismisses the alert
            state_nxt.alert         = 1'b0;
            state_nxt.dismiss_time  = ev.now_ms;
            state_nxt.dismiss_valid = 1'b1;
          end else if (cur.dismiss_valid && d_dismiss < cfg.dismiss_debounce_ms) begin
            // absorbed inside the debounce window
          end else begin
            state_nxt.dismiss_valid = 1'b0;
            if (cur.phase == PHASE_HOME) begin
              priority if (prog_sum < 0)
                state_nxt.progress = '0;
              else if (prog_sum > SUM_W'(MAX_PROGRESS))
                state_nxt.progress = PROG_W'(MAX_PROGRESS);
              else
                state_nxt.progress = prog_sum[PROG_W-1:0];
              changed = 1'b1;
            end
          end
        end
      end
      KIND_BUTTON: begin
        if (ev.pressed) begin
          state_nxt.last_input_time = ev.now_ms;
          state_nxt.alert           = 1'b0;
          if (ev.press_duration_ms >= cfg.press_long)
            state_nxt.dev_type = ~cur.dev_type;
        end
      end
      KIND_SET_LEVEL: begin
        state_nxt.progress = PROG_W'(int'(req_idx) * STEPS_PER_LEVEL);
        changed            = 1'b1;
      end
      KIND_RST_QUEUE: begin
        state_nxt.progress        = '0;
        state_nxt.alert           = 1'b0;
        state_nxt.last_input_time = ev.now_ms;
        changed                   = 1'b1;
      end
      KIND_DISMISS: begin
        if (cur.alert) begin
          state_nxt.alert           = 1'b0;
          state_nxt.dismiss_time    = ev.now_ms;
          state_nxt.dismiss_valid   = 1'b1;
          state_nxt.last_input_time = ev.now_ms;
          dismissed                 = 1'b1;
        end
      end
      default: begin
        // unused kinds leave the state alone
      end
    endcase
  end

  // Result reports the state after the event
  always_comb begin
    res_nxt.phase           = state_nxt.phase;
    res_nxt.level           = level_of(state_nxt.progress);
    res_nxt.detent          = sub_of(state_nxt.progress);
    res_nxt.inactive        = state_nxt.alert;
    res_nxt.unit_type       = state_nxt.dev_type;
    res_nxt.level_changed   = changed;
    res_nxt.alert_dismissed = dismissed;
  end

endmodule

`default_nettype wire

FILE: rtl/knob_level_inactivity_controller.sv
// ----------------------------------------------------------------------------
// knob_level_inactivity_controller - rotary knob queue level controller
// Tracks queue level from encoder, button and timer events, runs the boot
// and home phases and the inactivity alert with its dismiss debounce.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  kind, now_ms, delta, pressed,
//                                          press_duration_ms, level_request
//   out_     output     out_valid/out_stall phase, level, detent,
//                                          inactive, unit_type,
//                                          level_changed, alert_dismissed
//   cfg_     input      cfg_we             cfg_index, cfg_wdata
//
// One item per cycle while no result is held under out_stall; each result
// passes through the event register, then the single-pass update into the
// result register, before it is valid. Synchronous reset loads the register
// defaults and clears the state. While a result waits under out_stall both
// stages hold and in_stall is raised; otherwise in_stall is low.
// ----------------------------------------------------------------------------
`default_nettype none

module knob_level_inactivity_controller
  import klic_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // event channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [TIME_W-1:0]   in_now_ms,
  input  logic signed [DELTA_W-1:0] in_delta,
  input  logic                in_pressed,
  input  logic [TIME_W-1:0]   in_press_duration_ms,
  input  logic [REQ_W-1:0]    in_level_request,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_phase,
  output logic [LEVEL_W-1:0]  out_level,
  output logic [SUB_W-1:0]    out_detent,
  output logic                out_inactive,
  output logic                out_unit_type,
  output logic                out_level_changed,
  output logic                out_alert_dismissed,
  // register write port
  input  logic                cfg_we,
  input  logic [CIDX_W-1:0]   cfg_index,
  input  logic [TIME_W-1:0]   cfg_wdata
);

  logic   advance;
  logic   ev_valid_r;
  ev_t    ev_r;
  state_t state_r;
  state_t state_nxt;
  cfg_t   cfg_r;
  res_t   res_nxt;
  res_t   res_r;
  logic   out_valid_r;

  // Both stages move together unless a result is held
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance;

  // Event register
  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      ev_r.kind              <= in_kind;
      ev_r.now_ms            <= in_now_ms;
      ev_r.delta             <= in_delta;
      ev_r.pressed           <= in_pressed;
      ev_r.press_duration_ms <= in_press_duration_ms;
      ev_r.level_request     <= in_level_request;
    end
  end

  klic_step u_step (
    .cfg       (cfg_r),
    .cur       (state_r),
    .ev        (ev_r),
    .state_nxt (state_nxt),
    .res_nxt   (res_nxt)
  );

  // Control, state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_valid_r                    <= 1'b0;
      out_valid_r                   <= 1'b0;
      state_r.phase                 <= PHASE_BOOT;
      state_r.phase_enter_time      <= '0;
      state_r.last_input_time       <= '0;
      state_r.dismiss_time          <= '0;
      state_r.dismiss_valid         <= 1'b0;
      state_r.progress              <= '0;
      state_r.alert                 <= 1'b0;
      state_r.dev_type              <= INIT_TYPE_RST;
      cfg_r.boot_hold               <= BOOT_HOLD_RST;
      cfg_r.idle_timeout            <= INACT_TO_RST;
      cfg_r.dismiss_debounce_ms     <= DEBOUNCE_RST;
      cfg_r.press_long              <= LONG_PRESS_RST;
      cfg_r.init_unit_type          <= INIT_TYPE_RST;
    end else begin
      if (advance) begin
        ev_valid_r  <= in_valid;
        out_valid_r <= ev_valid_r;
        if (ev_valid_r) state_r <= state_nxt;
      end
      // the user must write registers only while idle; the block does not enforce it
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_BOOT_HOLD:  cfg_r.boot_hold           <= cfg_wdata;
          CFG_INACT_TO:   cfg_r.idle_timeout        <= cfg_wdata;
          CFG_DEBOUNCE:   cfg_r.dismiss_debounce_ms <= cfg_wdata;
          CFG_LONG_PRESS: cfg_r.press_long          <= cfg_wdata;
          CFG_INIT_TYPE: begin
            cfg_r.init_unit_type <= cfg_wdata[0];
            state_r.dev_type     <= cfg_wdata[0];
          end
          default: begin
            // unmapped index
          end
        endcase
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (advance && ev_valid_r) res_r <= res_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_phase           = res_r.phase;
  assign out_level           = res_r.level;
  assign out_detent          = res_r.detent;
  assign out_inactive        = res_r.inactive;
  assign out_unit_type       = res_r.unit_type;
  assign out_level_changed   = res_r.level_changed;
  assign out_alert_dismissed = res_r.alert_dismissed;

endmodule

`default_nettype wire

FILE: rtl/klic_checker.sv
// ----------------------------------------------------------------------------
// klic_checker - port-level checks for the knob level controller
// Watches the top-level ports only; attached by the bind below.
// ----------------------------------------------------------------------------
`default_nettype none

module klic_checker
  import klic_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_phase,
  input logic [LEVEL_W-1:0] out_level,
  input logic [SUB_W-1:0]   out_detent,
  input logic               out_inactive,
  input logic               out_alert_dismissed
);

  // Level and sub-step stay in their ranges
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_level >= LEVEL_W'(1) &&
                   out_level <= LEVEL_W'(NUM_LEVELS) &&
                   out_detent <= SUB_W'(STEPS_PER_LEVEL - 1)))
    else $error("queue level or sub-step out of range");

  // A dismissal always leaves the alert cleared
  a_dismiss_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_alert_dismissed |-> !out_inactive)
    else $error("alert still raised after dismissal");

  // Back-pressure only comes from a held result
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with no result pending");

  // A held result does not change
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_level)
                               && $stable(out_phase))
    else $error("stalled result changed");

endmodule

bind knob_level_inactivity_controller klic_checker u_klic_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_phase           (out_phase),
  .out_level           (out_level),
  .out_detent          (out_detent),
  .out_inactive        (out_inactive),
  .out_alert_dismissed (out_alert_dismissed)
);

`default_nettype wire
